@@ hw/rtl/wsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// wsrs_pkg: shared types and constants of the working-set range splitter
// Sizes of the page list, the interfaces between the store, the sequencer
// and the top level, and the mapping of region flags to an action.
// ----------------------------------------------------------------------------
package wsrs_pkg;

  localparam int WS_DEPTH = 1024;
  localparam int PAGE_W   = 36;
  localparam int IDX_W    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int CNT_W    = $clog2(WS_DEPTH + 1);

  localparam logic [2:0] FLAG_PRESENT = 3'd1;
  localparam logic [2:0] FLAG_LAZY    = 3'd2;

  typedef enum logic [1:0] {
    ACT_DUMP   = 2'd0,
    ACT_ACTIVE = 2'd1,
    ACT_SKIP   = 2'd2,
    ACT_ERROR  = 2'd3
  } action_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_SPLIT  = 1'b1
  } op_t;

  // Request from the sequencer to the page store.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [PAGE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // Status of the sequencer seen by the top level.
  typedef struct packed {
    logic             idle;
    logic             done;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } seq_status_t;

  typedef struct packed {
    logic [PAGE_W-1:0] len;
    logic              in_ws;
    logic [2:0]        flags;
  } seg_result_t;

  typedef struct packed {
    action_t action;
    logic    lazy;
  } act_t;

  function automatic act_t wsrs_action(input logic [2:0] flags, input logic in_ws);
    act_t r;
    if (flags == FLAG_PRESENT) begin
      r.action = ACT_DUMP;
      r.lazy   = 1'b0;
    end else if ((flags & FLAG_PRESENT) != 3'd0) begin
      r.action = in_ws ? ACT_ACTIVE : ACT_SKIP;
      r.lazy   = 1'b1;
    end else if (flags == FLAG_LAZY) begin
      r.action = ACT_SKIP;
      r.lazy   = 1'b1;
    end else begin
      r.action = ACT_ERROR;
      r.lazy   = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/wsrs_store.sv @@
// ----------------------------------------------------------------------------
// wsrs_store: working-set page list memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wsrs_store
  import wsrs_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [PAGE_W-1:0] rdata
);

  logic [PAGE_W-1:0] mem [WS_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hw/rtl/wsrs_seq.sv @@
// ----------------------------------------------------------------------------
// wsrs_seq: scan sequencer of the working-set range splitter
// Holds the list count and scan index, and walks the list one memory read
// at a time through a shared compare and subtract unit.
// ----------------------------------------------------------------------------
module wsrs_seq
  import wsrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  logic [PAGE_W-1:0] page,
  input  logic [PAGE_W-1:0] limit,
  input  logic [2:0]        flags,
  input  logic              ack,
  input  logic [PAGE_W-1:0] rdata,
  output mem_req_t          req,
  output seq_status_t       status,
  output seg_result_t       result
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_RD      = 6'b000010,
    S_CMP     = 6'b000100,
    S_RUN_RD  = 6'b001000,
    S_RUN_CMP = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PAGE_W-1:0] start_pg, limit_pg;
  logic [2:0]        flags_r;
  logic [PAGE_W-1:0] len, len_next;
  logic              in_ws, in_ws_next;

  logic              entry_valid;
  logic              more_ahead;
  logic              e_lt_start;
  logic              e_ge_limit;
  logic              e_eq_start;
  logic              run_match;
  logic              use_entry;
  logic [PAGE_W-1:0] sub_a;
  logic [PAGE_W-1:0] diff;
  logic [PAGE_W:0]   run_pos;

  // Shared unit: one subtractor against the start page, plus the compares.
  assign entry_valid = idx < count;
  assign more_ahead  = ({1'b0, idx} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, count};
  assign e_lt_start  = rdata < start_pg;
  assign e_ge_limit  = rdata >= limit_pg;
  assign e_eq_start  = rdata == start_pg;
  assign run_pos     = {1'b0, start_pg} + {1'b0, len};
  assign run_match   = !e_ge_limit && (run_pos == {1'b0, rdata});
  assign use_entry   = (state == S_CMP) && !e_lt_start && !e_ge_limit;
  assign sub_a       = use_entry ? rdata : limit_pg;
  assign diff        = sub_a - start_pg;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    len_next   = len;
    in_ws_next = in_ws;
    req        = '0;
    req.waddr  = count[IDX_W-1:0];
    req.wdata  = page;
    req.raddr  = idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_SPLIT) begin
            state_next = S_RD;
          end else if (count != CNT_W'(WS_DEPTH)) begin
            req.we     = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
      end
      S_RD: begin
        // An index at or past the list end counts as no entry.
        if (!entry_valid) begin
          len_next   = diff;
          in_ws_next = 1'b0;
          state_next = S_DONE;
        end else begin
          req.re     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (more_ahead && e_lt_start) begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_RD;
        end else if (e_lt_start || e_ge_limit || !e_eq_start) begin
          len_next   = diff;
          in_ws_next = 1'b0;
          state_next = S_DONE;
        end else begin
          len_next   = PAGE_W'(1);
          in_ws_next = 1'b1;
          idx_next   = idx + CNT_W'(1);
          state_next = S_RUN_RD;
        end
      end
      S_RUN_RD: begin
        if (!entry_valid) begin
          state_next = S_DONE;
        end else begin
          req.re     = 1'b1;
          state_next = S_RUN_CMP;
        end
      end
      S_RUN_CMP: begin
        if (run_match) begin
          len_next   = len + PAGE_W'(1);
          idx_next   = idx + CNT_W'(1);
          state_next = S_RUN_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      start_pg <= page;
      limit_pg <= limit;
      flags_r  <= flags;
    end
    len   <= len_next;
    in_ws <= in_ws_next;
  end

  assign status.idle   = state == S_IDLE;
  assign status.done   = state == S_DONE;
  assign status.idx    = idx;
  assign status.count  = count;
  assign result.len    = len;
  assign result.in_ws  = in_ws;
  assign result.flags  = flags_r;

endmodule

@@ hw/rtl/working_set_range_splitter.sv @@
// ----------------------------------------------------------------------------
// working_set_range_splitter: top level
// An append transaction leaves the block ready. A split transaction scans
// past the list entries below the start page and then through the pages in
// the run to a valid result, and gives its result without a memory read when
// the list is empty or the scan index already sits at its end. The input is
// ready again once the result is in the output register, which lets the next
// transaction start while it waits. Reset clears the list count, the scan
// index and the handshake; the list memory holds no reset value.
// ----------------------------------------------------------------------------
module working_set_range_splitter
  import wsrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [PAGE_W-1:0] page_number,
  input  logic [PAGE_W-1:0] limit_page,
  input  logic [2:0]        region_flags,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PAGE_W-1:0] segment_pages,
  output logic              in_working_set,
  output logic [1:0]        action,
  output logic              mark_lazy
);

  mem_req_t          req;
  seq_status_t       status;
  seg_result_t       result;
  logic [PAGE_W-1:0] rdata;
  logic              accept;
  logic              load;
  act_t              act;

  assign in_ready = status.idle;
  assign accept   = in_valid && in_ready;
  assign load     = status.done && (!out_valid || out_ready);
  assign act      = wsrs_action(result.flags, result.in_ws);

  wsrs_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  wsrs_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .op     (operation),
    .page   (page_number),
    .limit  (limit_page),
    .flags  (region_flags),
    .ack    (load),
    .rdata  (rdata),
    .req    (req),
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      segment_pages  <= result.len;
      in_working_set <= result.in_ws;
      action         <= act.action;
      mark_lazy      <= act.lazy;
    end
  end

  // The scan index never runs past the end of the list.
  a_idx_in_list: assert property (@(posedge clk) disable iff (rst)
    status.idx <= status.count)
    else $error("scan index beyond list count");

  // The list never grows past its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(WS_DEPTH))
    else $error("list count beyond capacity");

  // A split transaction starts a scan; an append one leaves the block ready.
  a_split_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_SPLIT) |=> !in_ready)
    else $error("split transaction did not start a scan");

  a_append_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_APPEND) |=> in_ready && $stable(status.idx))
    else $error("append transaction disturbed the scan");

  // A new result appears only after the sequencer finished a scan.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(status.done))
    else $error("result presented without a finished scan");

endmodule
